/* hdl/raycast_wall_column_texturer_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the wall column texturer
// Shared concurrent assertion forms; clock i_clk, reset i_rst_n.
// ----------------------------------------------------------------------------
`ifndef RAYCAST_WALL_COLUMN_TEXTURER_DEFINES_SVH
`define RAYCAST_WALL_COLUMN_TEXTURER_DEFINES_SVH

// same-cycle implication
`define RWCT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RWCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/rwct_pkg.sv */
// ----------------------------------------------------------------------------
// Wall column texturer package
// Command codes, register indexes, fixed widths and constants, and the pixel record.
// ----------------------------------------------------------------------------
package rwct_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_START = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    localparam logic [0:0] CFG_TEX_WIDTH = 1'b0;
    localparam logic [0:0] CFG_TEX_HLOG  = 1'b1;

    localparam logic [23:0] HALF_MASK = 24'h7F7F7F;
    localparam logic [2:0]  HLOG_MAX  = 3'd6;
    localparam int          STORE_AW  = 14;
    localparam int          OFS_W     = 12;
    localparam int          COL_W     = 7;
    localparam int          STEP_W    = 23;
    localparam logic [4:0]  DIV_LAST  = 5'd22;

    typedef struct packed {
        logic [15:0] col;
        logic [9:0]  row;
        logic        last;
        logic        shade;
    } t_pix;

endpackage

/* hdl/raycast_wall_column_texturer.sv */
// ----------------------------------------------------------------------------
// Raycast wall column texturer
// Texture store, per-column setup on a shared multiplier and serial divider,
// and a streaming pixel path with a registered texel read.
// ----------------------------------------------------------------------------
//  channel  valid         stall         payload
//  input    i_in_valid    o_in_stall    i_cmd .. i_end_row
//  output   o_out_valid   i_out_stall   o_screen_col .. o_last_pixel
//  config   i_cfg_we      -             i_cfg_index, i_cfg_data
//
// Pixel ticks stream one per cycle while o_in_stall is low.
// A column start holds input stall through hit multiply, column multiply,
// 23 steps of the restoring divider, position multiply and commit.
// After its tick, a pixel passes the texel read register, then the output register.
// Reset is synchronous; the texture store is not cleared.
// Output stall backs up through one stage and then stalls the input.
// ----------------------------------------------------------------------------
`include "raycast_wall_column_texturer_defines.svh"

module raycast_wall_column_texturer #(
    parameter int SCREEN_HEIGHT = 1024,
    parameter int MAX_TEX_DIM   = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_index,
    input  logic [6:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_cmd,
    input  logic [13:0]        i_texel_index,
    input  logic [23:0]        i_texel_value,
    input  logic               i_hit_side,
    input  logic signed [17:0] i_ray_dir_x,
    input  logic signed [17:0] i_ray_dir_y,
    input  logic [23:0]        i_eye_x,
    input  logic [23:0]        i_eye_y,
    input  logic [23:0]        i_wall_distance,
    input  logic [15:0]        i_wall_height,
    input  logic [9:0]         i_first_row,
    input  logic [10:0]        i_end_row,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [15:0]        o_screen_col,
    output logic [9:0]         o_screen_row,
    output logic [23:0]        o_pixel_color,
    output logic               o_last_pixel
);
    import rwct_pkg::*;

    localparam logic signed [17:0] HALF_H = 18'(SCREEN_HEIGHT / 2);
    localparam logic [10:0]        ROWS   = 11'(SCREEN_HEIGHT);

    typedef enum logic [2:0] {
        S_IDLE, S_HIT, S_COL, S_DIV, S_POS, S_DONE
    } t_state;

    t_state r_state;

    logic [6:0]  r_tex_width;
    logic [2:0]  r_tex_hlog;
    logic [15:0] r_col_cnt;
    logic [10:0] r_cur_row;
    logic [10:0] r_stop_row;
    logic [39:0] r_tex_pos;
    logic [31:0] r_tex_step;
    logic [COL_W-1:0] r_tex_col;
    logic [1:0]  r_tex_sel;
    logic        r_shade;

    // column setup operands
    logic               r_c_mirror;
    logic [15:0]        r_c_eye;
    logic [23:0]        r_c_dist;
    logic signed [17:0] r_c_rd;
    logic [15:0]        r_c_lh;
    logic signed [17:0] r_c_start;
    logic [9:0]         r_c_first;
    logic [10:0]        r_c_end;

    logic [57:0]       r_prod;
    logic [15:0]       r_rem;
    logic [STEP_W-1:0] r_quo;
    logic [4:0]        r_div_cnt;

    logic        r_b_valid;
    t_pix        r_b;
    logic [23:0] r_mem_q;
    logic [23:0] r_store [0:(1 << STORE_AW) - 1];

    logic        r_out_valid;
    logic [15:0] r_out_col;
    logic [9:0]  r_out_row;
    logic [23:0] r_out_color;
    logic        r_out_last;

    logic [6:0]  w_eff;
    logic [2:0]  hlog_eff;
    logic [5:0]  hmask;
    logic        out_load;
    logic        b_adv;
    logic        in_acc;
    logic        tick_emit;
    logic [5:0]  tex_row;
    logic [12:0] row_ofs;
    logic [13:0] tex_ofs;
    logic [STORE_AW-1:0] rd_addr;
    logic [15:0] lh_fix;
    logic signed [17:0] start_val;
    logic [31:0] frac;
    logic signed [32:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [57:0] mul_p;
    logic [16:0] rem_sh;
    logic        div_ge;
    logic [6:0]  col_raw;

    always_comb begin
        priority if (r_tex_width == 7'd0) begin
            w_eff = 7'd1;
        end else if (int'(r_tex_width) > MAX_TEX_DIM) begin
            w_eff = 7'(MAX_TEX_DIM);
        end else begin
            w_eff = r_tex_width;
        end
    end

    assign hlog_eff = (r_tex_hlog > HLOG_MAX) ? HLOG_MAX : r_tex_hlog;
    assign hmask    = 6'((7'd1 << hlog_eff) - 7'd1);

    assign out_load   = !r_out_valid || !i_out_stall;
    assign b_adv      = r_b_valid && out_load;
    assign o_in_stall = (r_state != S_IDLE) || (r_b_valid && !out_load);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign tick_emit  = in_acc && (i_cmd == CMD_TICK) && (r_cur_row < r_stop_row);

    // row = position truncated toward zero, low bits only
    assign tex_row = (r_tex_pos[21:16] + {5'd0, r_tex_pos[39] & (|r_tex_pos[15:0])}) & hmask;
    assign row_ofs = 13'(w_eff) * 13'(tex_row);
    assign tex_ofs = {1'b0, row_ofs} + 14'(r_tex_col);
    assign rd_addr = {r_tex_sel, tex_ofs[OFS_W-1:0]};

    assign lh_fix    = (i_wall_height == 16'd0) ? 16'd1 : i_wall_height;
    assign start_val = $signed({8'd0, i_first_row}) - HALF_H + $signed({3'd0, lh_fix[15:1]});

    assign frac = {r_c_eye, 16'd0} + r_prod[31:0];

    always_comb begin
        unique case (r_state)
            S_HIT: begin
                mul_a = $signed({9'd0, r_c_dist});
                mul_b = $signed({{7{r_c_rd[17]}}, r_c_rd});
            end
            S_COL: begin
                mul_a = $signed({1'b0, frac});
                mul_b = $signed({18'd0, w_eff});
            end
            S_POS: begin
                mul_a = $signed({10'd0, r_quo});
                mul_b = $signed({{7{r_c_start[17]}}, r_c_start});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 58'(mul_a) * 58'(mul_b);

    assign rem_sh  = {r_rem, r_quo[STEP_W-1]};
    assign div_ge  = rem_sh >= {1'b0, r_c_lh};
    assign col_raw = r_prod[38:32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tex_width <= 7'd64;
            r_tex_hlog  <= 3'd6;
            r_col_cnt   <= '0;
            r_cur_row   <= '0;
            r_stop_row  <= '0;
            r_tex_pos   <= '0;
            r_tex_step  <= '0;
            r_tex_col   <= '0;
            r_tex_sel   <= '0;
            r_shade     <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_div_cnt   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_TEX_WIDTH: r_tex_width <= i_cfg_data;
                    CFG_TEX_HLOG:  r_tex_hlog  <= i_cfg_data[2:0];
                endcase
            end

            if (tick_emit) begin
                r_b_valid <= 1'b1;
                r_cur_row <= r_cur_row + 11'd1;
                r_tex_pos <= r_tex_pos + {8'd0, r_tex_step};
            end else if (b_adv) begin
                r_b_valid <= 1'b0;
            end

            if (out_load) begin
                r_out_valid <= r_b_valid;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && i_cmd == CMD_START) begin
                        r_state <= S_HIT;
                        r_shade <= i_hit_side;
                        if (!i_hit_side) begin
                            r_tex_sel <= (i_ray_dir_x > 0) ? 2'd3 : 2'd2;
                        end else begin
                            r_tex_sel <= (i_ray_dir_y > 0) ? 2'd1 : 2'd0;
                        end
                    end
                end
                S_HIT: begin
                    r_state <= S_COL;
                end
                S_COL: begin
                    r_state   <= S_DIV;
                    r_div_cnt <= '0;
                end
                S_DIV: begin
                    if (r_div_cnt == 5'd0) begin
                        r_tex_col <= r_c_mirror ? (w_eff - 7'd1 - col_raw) : col_raw;
                    end
                    r_div_cnt <= r_div_cnt + 5'd1;
                    if (r_div_cnt == DIV_LAST) begin
                        r_state <= S_POS;
                    end
                end
                S_POS: begin
                    r_state    <= S_DONE;
                    r_tex_step <= 32'(r_quo);
                end
                S_DONE: begin
                    r_state    <= S_IDLE;
                    r_tex_pos  <= r_prod[39:0];
                    r_cur_row  <= {1'b0, r_c_first};
                    r_stop_row <= r_c_end;
                    r_col_cnt  <= r_col_cnt + 16'd1;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc && i_cmd == CMD_START) begin
            r_c_mirror <= (!i_hit_side && i_ray_dir_x > 0) || (i_hit_side && i_ray_dir_x < 0);
            r_c_eye    <= i_hit_side ? i_eye_x[15:0] : i_eye_y[15:0];
            r_c_rd     <= i_hit_side ? i_ray_dir_x : i_ray_dir_y;
            r_c_dist   <= i_wall_distance;
            r_c_lh     <= lh_fix;
            r_c_start  <= start_val;
            r_c_first  <= i_first_row;
            r_c_end    <= (i_end_row > ROWS) ? ROWS : i_end_row;
        end
        if (r_state == S_HIT || r_state == S_COL || r_state == S_POS) begin
            r_prod <= mul_p;
        end
        if (r_state == S_COL) begin
            r_rem <= '0;
            r_quo <= 23'd65536 << hlog_eff;
        end else if (r_state == S_DIV) begin
            r_rem <= div_ge ? 16'(rem_sh - {1'b0, r_c_lh}) : rem_sh[15:0];
            r_quo <= {r_quo[STEP_W-2:0], div_ge};
        end
        if (tick_emit) begin
            r_b.col   <= r_col_cnt - 16'd1;
            r_b.row   <= r_cur_row[9:0];
            r_b.last  <= (r_cur_row + 11'd1) == r_stop_row;
            r_b.shade <= r_shade;
        end
        if (out_load && r_b_valid) begin
            r_out_col   <= r_b.col;
            r_out_row   <= r_b.row;
            r_out_last  <= r_b.last;
            r_out_color <= r_b.shade ? ((r_mem_q >> 1) & HALF_MASK) : r_mem_q;
        end
    end

    // texture store
    always_ff @(posedge i_clk) begin
        if (in_acc && i_cmd == CMD_WRITE) begin
            r_store[i_texel_index] <= i_texel_value;
        end
        if (tick_emit) begin
            r_mem_q <= r_store[rd_addr];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_screen_col  = r_out_col;
    assign o_screen_row  = r_out_row;
    assign o_pixel_color = r_out_color;
    assign o_last_pixel  = r_out_last;

    `RWCT_ASSERT_NEXT(a_start_busy, i_rst_n && in_acc && i_cmd == CMD_START, o_in_stall, "column start did not hold input")
    `RWCT_ASSERT_NEXT(a_col_count, i_rst_n && r_state == S_DONE, r_col_cnt == $past(r_col_cnt) + 16'd1, "column counter did not advance")
    `RWCT_ASSERT_NEXT(a_b_hold, i_rst_n && r_b_valid && !out_load, r_b_valid, "pending pixel dropped")
    `RWCT_ASSERT_NOW(a_div_range, r_state == S_DIV, r_div_cnt <= DIV_LAST, "divider ran past its last step")

endmodule
